// ===== hw/rtl/mrtu_pkg.sv =====
package mrtu_pkg;

    typedef enum logic [2:0] {
        ST_WAIT,
        ST_FRAME,
        ST_CRC,
        ST_EMIT,
        ST_RXCRC,
        ST_ONE
    } t_state;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_TURN,
        PH_LISTEN,
        PH_GAP
    } t_phase;

    typedef struct packed {
        logic init;
        logic load;
        logic step;
    } t_crc_ctl;

    localparam logic [1:0] CMD_READ  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_RX    = 2'd2;
    localparam logic [1:0] CMD_TICK  = 2'd3;

    localparam logic [1:0] KIND_TX      = 2'd0;
    localparam logic [1:0] KIND_RELEASE = 2'd1;
    localparam logic [1:0] KIND_DONE    = 2'd2;

    localparam logic [2:0] REG_SLAVE   = 3'd0;
    localparam logic [2:0] REG_RETRY   = 3'd1;
    localparam logic [2:0] REG_TIMEOUT = 3'd2;
    localparam logic [2:0] REG_RD_TURN = 3'd3;
    localparam logic [2:0] REG_WR_TURN = 3'd4;
    localparam logic [2:0] REG_GAP     = 3'd5;

    localparam logic [3:0] RD_FRAME_LEN = 4'd8;
    localparam logic [3:0] WR_FRAME_LEN = 4'd11;
    localparam logic [2:0] RD_REPLY_LEN = 3'd6;
    localparam logic [3:0] WR_REPLY_LEN = 4'd8;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    function automatic logic [7:0] frame_byte(
        input logic        is_write,
        input logic [3:0]  idx,
        input logic [7:0]  addr,
        input logic [15:0] reg_addr,
        input logic [15:0] reg_val,
        input logic [15:0] crc
    );
        logic [7:0] b;
        b = 8'h00;
        if (idx == 4'd0) begin
            b = addr;
        end else if (is_write) begin
            case (idx)
                4'd1:    b = 8'h10;
                4'd2:    b = reg_addr[15:8];
                4'd3:    b = reg_addr[7:0];
                4'd4:    b = 8'h00;
                4'd5:    b = 8'h01;
                4'd6:    b = 8'h02;
                4'd7:    b = reg_val[15:8];
                4'd8:    b = reg_val[7:0];
                4'd9:    b = crc[7:0];
                default: b = crc[15:8];
            endcase
        end else begin
            case (idx)
                4'd1:    b = 8'h01;
                4'd2:    b = 8'h00;
                4'd3:    b = 8'h06;
                4'd4:    b = 8'h00;
                4'd5:    b = 8'h07;
                4'd6:    b = crc[7:0];
                default: b = crc[15:8];
            endcase
        end
        return b;
    endfunction

endpackage

// ===== hw/rtl/mrtu_if.sv =====
interface mrtu_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [15:0] register_address;
    logic [15:0] register_value;
    logic [7:0]  rx_byte;
    modport source (output valid, command, register_address, register_value, rx_byte,
                    input ready);
    modport sink (input valid, command, register_address, register_value, rx_byte,
                  output ready);
endinterface

interface mrtu_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] tx_data;
    logic       last;
    logic       success;
    logic [7:0] reply_value;
    modport source (output valid, kind, tx_data, last, success, reply_value, input ready);
    modport sink (input valid, kind, tx_data, last, success, reply_value, output ready);
endinterface

interface mrtu_cfg_if;
    logic       valid;
    logic       ready;
    logic [2:0] index;
    logic [9:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/mrtu_crc.sv =====
module mrtu_crc (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  mrtu_pkg::t_crc_ctl  i_ctl,
    input  logic [7:0]          i_byte,
    output logic [15:0]         o_crc
);
    logic [15:0] r_crc;
    logic [15:0] n_crc;

    always_comb begin
        n_crc = r_crc;
        if (i_ctl.load) begin
            n_crc = (i_ctl.init ? mrtu_pkg::CRC_INIT : r_crc) ^ {8'h00, i_byte};
        end else if (i_ctl.step) begin
            // one bit of the reflected polynomial division
            n_crc = {1'b0, r_crc[15:1]} ^ (r_crc[0] ? mrtu_pkg::CRC_POLY : 16'h0000);
        end else if (i_ctl.init) begin
            n_crc = mrtu_pkg::CRC_INIT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc <= mrtu_pkg::CRC_INIT;
        end else begin
            r_crc <= n_crc;
        end
    end

    assign o_crc = r_crc;
endmodule

// ===== hw/rtl/modbus_rtu_master_transaction_top.sv =====
// Modbus RTU master for one slave. Commands, received bytes and millisecond
// ticks enter on i_in; frame bytes, driver release and the done report leave
// on o_out, one transfer per result, the last result of an item flagged.
// The CRC-16 runs one bit per clock in a shared shift unit, so a CRC-covered
// frame byte goes through load, 8 CRC shifts and emit, and each CRC byte only
// through fetch and emit; an output stall holds a frame in its emit step. A
// CRC-covered reply byte is loaded when taken and then gets 8 CRC shifts;
// other items take no shifts. One item is worked at a time; the next
// is taken once all results of the current one sit in or have left the output
// register. Configuration writes on i_cfg are always taken and must happen
// while idle.
module modbus_rtu_master_transaction_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mrtu_in_if.sink     i_in,
    mrtu_out_if.source  o_out,
    mrtu_cfg_if.sink    i_cfg
);
    mrtu_pkg::t_state r_state, n_state;
    mrtu_pkg::t_phase r_phase, n_phase;

    logic [7:0]  r_slave;
    logic [3:0]  r_retry;
    logic [9:0]  r_timeout, r_rd_turn, r_wr_turn, r_gap;

    logic        r_is_write, n_is_write;
    logic [15:0] r_ra, n_ra, r_rv, n_rv;
    logic [2:0]  r_count, n_count;
    logic [9:0]  r_timer, n_timer;
    logic [3:0]  r_att, n_att;
    logic [3:0]  r_idx, n_idx;
    logic [2:0]  r_bit, n_bit;
    logic        r_lo_ok, n_lo_ok;
    logic [7:0]  r_val3, n_val3;
    logic [1:0]  r_one_kind, n_one_kind;
    logic        r_one_ok, n_one_ok;
    logic [7:0]  r_one_val, n_one_val;

    logic        r_ov, n_ov;
    logic [1:0]  r_okind, n_okind;
    logic [7:0]  r_otx, n_otx;
    logic        r_olast, n_olast;
    logic        r_ook, n_ook;
    logic [7:0]  r_oval, n_oval;

    mrtu_pkg::t_crc_ctl crc_ctl;
    logic [7:0]  crc_byte;
    logic [15:0] crc;

    logic        accept, can_load;
    logic [3:0]  frame_len, need, att_inc;
    logic [7:0]  fbyte;
    logic        timer_end;

    mrtu_crc u_crc (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_ctl  (crc_ctl),
        .i_byte (crc_byte),
        .o_crc  (crc)
    );

    assign accept    = i_in.valid && i_in.ready;
    assign can_load  = !r_ov || o_out.ready;
    assign frame_len = r_is_write ? mrtu_pkg::WR_FRAME_LEN : mrtu_pkg::RD_FRAME_LEN;
    assign need      = r_is_write ? mrtu_pkg::WR_REPLY_LEN : {1'b0, mrtu_pkg::RD_REPLY_LEN};
    assign att_inc   = r_att + 4'd1;
    assign timer_end = r_timer <= 10'd1;
    assign fbyte     = mrtu_pkg::frame_byte(r_is_write, r_idx, r_slave, r_ra, r_rv, crc);

    assign i_in.ready  = (r_state == mrtu_pkg::ST_WAIT);
    assign i_cfg.ready = 1'b1;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            mrtu_pkg::ST_WAIT: begin
                if (accept) begin
                    case (i_in.command)
                        mrtu_pkg::CMD_READ, mrtu_pkg::CMD_WRITE: begin
                            if (r_phase == mrtu_pkg::PH_IDLE) n_state = mrtu_pkg::ST_FRAME;
                        end
                        mrtu_pkg::CMD_RX: begin
                            if (r_phase == mrtu_pkg::PH_LISTEN) begin
                                if ({1'b0, r_count} + 4'd2 < need) begin
                                    n_state = mrtu_pkg::ST_RXCRC;
                                end else if ({1'b0, r_count} + 4'd1 == need) begin
                                    if ((r_lo_ok && i_in.rx_byte == crc[15:8]) ||
                                        att_inc >= r_retry || att_inc == 4'd0) begin
                                        n_state = mrtu_pkg::ST_ONE;
                                    end
                                end
                            end
                        end
                        default: begin
                            if (timer_end) begin
                                if (r_phase == mrtu_pkg::PH_TURN) begin
                                    n_state = mrtu_pkg::ST_ONE;
                                end else if (r_phase == mrtu_pkg::PH_LISTEN) begin
                                    if (att_inc >= r_retry || att_inc == 4'd0)
                                        n_state = mrtu_pkg::ST_ONE;
                                end else if (r_phase == mrtu_pkg::PH_GAP) begin
                                    n_state = mrtu_pkg::ST_FRAME;
                                end
                            end
                        end
                    endcase
                end
            end
            mrtu_pkg::ST_FRAME: begin
                n_state = (r_idx + 4'd2 < frame_len) ? mrtu_pkg::ST_CRC : mrtu_pkg::ST_EMIT;
            end
            mrtu_pkg::ST_CRC: begin
                if (r_bit == 3'd7) n_state = mrtu_pkg::ST_EMIT;
            end
            mrtu_pkg::ST_EMIT: begin
                if (can_load) begin
                    n_state = (r_idx + 4'd1 == frame_len) ? mrtu_pkg::ST_WAIT
                                                          : mrtu_pkg::ST_FRAME;
                end
            end
            mrtu_pkg::ST_RXCRC: begin
                if (r_bit == 3'd7) n_state = mrtu_pkg::ST_WAIT;
            end
            mrtu_pkg::ST_ONE: begin
                if (can_load) n_state = mrtu_pkg::ST_WAIT;
            end
            default: n_state = mrtu_pkg::ST_WAIT;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_phase    = r_phase;
        n_is_write = r_is_write;
        n_ra       = r_ra;
        n_rv       = r_rv;
        n_count    = r_count;
        n_timer    = r_timer;
        n_att      = r_att;
        n_idx      = r_idx;
        n_bit      = r_bit;
        n_lo_ok    = r_lo_ok;
        n_val3     = r_val3;
        n_one_kind = r_one_kind;
        n_one_ok   = r_one_ok;
        n_one_val  = r_one_val;
        n_ov       = r_ov && !o_out.ready;
        n_okind    = r_okind;
        n_otx      = r_otx;
        n_olast    = r_olast;
        n_ook      = r_ook;
        n_oval     = r_oval;
        crc_ctl    = '0;
        crc_byte   = fbyte;

        unique case (r_state)
            mrtu_pkg::ST_WAIT: begin
                if (accept) begin
                    case (i_in.command)
                        mrtu_pkg::CMD_READ, mrtu_pkg::CMD_WRITE: begin
                            if (r_phase == mrtu_pkg::PH_IDLE) begin
                                n_is_write = i_in.command[0];
                                if (i_in.command == mrtu_pkg::CMD_WRITE) begin
                                    n_ra = i_in.register_address;
                                    n_rv = i_in.register_value;
                                end
                                n_att = 4'd0;
                                n_idx = 4'd0;
                            end
                        end
                        mrtu_pkg::CMD_RX: begin
                            if (r_phase == mrtu_pkg::PH_LISTEN) begin
                                crc_byte = i_in.rx_byte;
                                n_count  = r_count + 3'd1;
                                n_bit    = 3'd0;
                                if (r_count == 3'd3) n_val3 = i_in.rx_byte;
                                if ({1'b0, r_count} + 4'd2 < need) begin
                                    crc_ctl.load = 1'b1;
                                end else if ({1'b0, r_count} + 4'd2 == need) begin
                                    n_lo_ok = (i_in.rx_byte == crc[7:0]);
                                end else begin
                                    n_one_kind = mrtu_pkg::KIND_DONE;
                                    n_one_val  = 8'h00;
                                    if (r_lo_ok && i_in.rx_byte == crc[15:8]) begin
                                        n_one_ok = 1'b1;
                                        if (!r_is_write) n_one_val = r_val3;
                                        n_phase = mrtu_pkg::PH_IDLE;
                                    end else begin
                                        n_one_ok = 1'b0;
                                        n_att    = att_inc;
                                        if (att_inc >= r_retry || att_inc == 4'd0) begin
                                            n_phase = mrtu_pkg::PH_IDLE;
                                        end else begin
                                            n_phase = mrtu_pkg::PH_GAP;
                                            n_timer = r_gap;
                                        end
                                    end
                                end
                            end
                        end
                        default: begin
                            if (r_phase != mrtu_pkg::PH_IDLE) begin
                                n_timer = r_timer - 10'd1;
                                if (timer_end) begin
                                    n_timer = r_timer;
                                    if (r_phase == mrtu_pkg::PH_TURN) begin
                                        n_one_kind   = mrtu_pkg::KIND_RELEASE;
                                        n_one_ok     = 1'b0;
                                        n_one_val    = 8'h00;
                                        n_phase      = mrtu_pkg::PH_LISTEN;
                                        n_count      = 3'd0;
                                        n_timer      = r_timeout;
                                        crc_ctl.init = 1'b1;
                                    end else if (r_phase == mrtu_pkg::PH_LISTEN) begin
                                        n_att = att_inc;
                                        if (att_inc >= r_retry || att_inc == 4'd0) begin
                                            n_one_kind = mrtu_pkg::KIND_DONE;
                                            n_one_ok   = 1'b0;
                                            n_one_val  = 8'h00;
                                            n_phase    = mrtu_pkg::PH_IDLE;
                                        end else begin
                                            n_phase = mrtu_pkg::PH_GAP;
                                            n_timer = r_gap;
                                        end
                                    end else begin
                                        n_idx = 4'd0;
                                    end
                                end
                            end
                        end
                    endcase
                end
            end
            mrtu_pkg::ST_FRAME: begin
                n_bit = 3'd0;
                if (r_idx + 4'd2 < frame_len) begin
                    crc_ctl.load = 1'b1;
                    crc_ctl.init = (r_idx == 4'd0);
                end
            end
            mrtu_pkg::ST_CRC, mrtu_pkg::ST_RXCRC: begin
                crc_ctl.step = 1'b1;
                n_bit        = r_bit + 3'd1;
            end
            mrtu_pkg::ST_EMIT: begin
                if (can_load) begin
                    n_ov    = 1'b1;
                    n_okind = mrtu_pkg::KIND_TX;
                    n_otx   = fbyte;
                    n_ook   = 1'b0;
                    n_oval  = 8'h00;
                    n_olast = (r_idx + 4'd1 == frame_len);
                    n_idx   = r_idx + 4'd1;
                    if (r_idx + 4'd1 == frame_len) begin
                        n_phase = mrtu_pkg::PH_TURN;
                        n_timer = r_is_write ? r_wr_turn : r_rd_turn;
                    end
                end
            end
            mrtu_pkg::ST_ONE: begin
                if (can_load) begin
                    n_ov    = 1'b1;
                    n_okind = r_one_kind;
                    n_otx   = 8'h00;
                    n_ook   = r_one_ok;
                    n_oval  = r_one_val;
                    n_olast = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= mrtu_pkg::ST_WAIT;
            r_phase   <= mrtu_pkg::PH_IDLE;
            r_ov      <= 1'b0;
            r_slave   <= 8'd1;
            r_retry   <= 4'd10;
            r_timeout <= 10'd100;
            r_rd_turn <= 10'd5;
            r_wr_turn <= 10'd13;
            r_gap     <= 10'd100;
            r_is_write <= 1'b0;
            r_ra      <= 16'h0000;
            r_rv      <= 16'h0000;
            r_count   <= 3'd0;
            r_timer   <= 10'd0;
            r_att     <= 4'd0;
            r_idx     <= 4'd0;
            r_bit     <= 3'd0;
        end else begin
            r_state    <= n_state;
            r_phase    <= n_phase;
            r_ov       <= n_ov;
            r_is_write <= n_is_write;
            r_ra       <= n_ra;
            r_rv       <= n_rv;
            r_count    <= n_count;
            r_timer    <= n_timer;
            r_att      <= n_att;
            r_idx      <= n_idx;
            r_bit      <= n_bit;
            if (i_cfg.valid) begin
                case (i_cfg.index)
                    mrtu_pkg::REG_SLAVE:   r_slave   <= i_cfg.data[7:0];
                    mrtu_pkg::REG_RETRY:   r_retry   <= i_cfg.data[3:0];
                    mrtu_pkg::REG_TIMEOUT: r_timeout <= i_cfg.data;
                    mrtu_pkg::REG_RD_TURN: r_rd_turn <= i_cfg.data;
                    mrtu_pkg::REG_WR_TURN: r_wr_turn <= i_cfg.data;
                    mrtu_pkg::REG_GAP:     r_gap     <= i_cfg.data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo_ok    <= n_lo_ok;
        r_val3     <= n_val3;
        r_one_kind <= n_one_kind;
        r_one_ok   <= n_one_ok;
        r_one_val  <= n_one_val;
        r_okind    <= n_okind;
        r_otx      <= n_otx;
        r_olast    <= n_olast;
        r_ook      <= n_ook;
        r_oval     <= n_oval;
    end

    assign o_out.valid       = r_ov;
    assign o_out.kind        = r_okind;
    assign o_out.tx_data     = r_otx;
    assign o_out.last        = r_olast;
    assign o_out.success     = r_ook;
    assign o_out.reply_value = r_oval;
endmodule

// ===== hw/rtl/mrtu_chk.sv =====
module mrtu_chk (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [1:0] i_out_kind,
    input logic       i_out_last,
    input logic       i_out_success,
    input logic [7:0] i_out_reply_value
);
    // a frame still in progress keeps new items out
    a_busy_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_last) |-> !i_in_ready)
        else $error("input taken while a frame is still being sent");

    a_kind_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_kind <= mrtu_pkg::KIND_DONE))
        else $error("undefined result kind");

    a_tx_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_kind != mrtu_pkg::KIND_DONE) |->
            (!i_out_success && i_out_reply_value == 8'h00))
        else $error("status fields set on a non-done result");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_kind)))
        else $error("result dropped while stalled");
endmodule

bind modbus_rtu_master_transaction_top mrtu_chk u_mrtu_chk (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_ready       (i_in.ready),
    .i_out_valid      (o_out.valid),
    .i_out_ready      (o_out.ready),
    .i_out_kind       (o_out.kind),
    .i_out_last       (o_out.last),
    .i_out_success    (o_out.success),
    .i_out_reply_value(o_out.reply_value)
);

// ===== verif/mrtu_checker.sv =====
module mrtu_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mrtu_in_if          i_in,
    mrtu_out_if         i_out,
    mrtu_cfg_if         i_cfg,
    output int          o_errors,
    output int          o_pending,
    output int          o_results
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] tx_data;
        logic       last;
        logic       success;
        logic [7:0] reply_value;
    } t_result;

    t_result     pending_results[$];

    logic [7:0]  cfg_slave;
    logic [3:0]  cfg_retry;
    logic [9:0]  cfg_timeout;
    logic [9:0]  cfg_rd_turn;
    logic [9:0]  cfg_wr_turn;
    logic [9:0]  cfg_gap;

    mrtu_pkg::t_phase mdl_phase;
    logic        mdl_write;
    logic [15:0] mdl_reg_addr;
    logic [15:0] mdl_reg_val;
    logic [7:0]  mdl_reply[8];
    logic [3:0]  mdl_count;
    logic [15:0] mdl_crc;
    logic [9:0]  mdl_timer;
    logic [3:0]  mdl_attempts;

    assign o_pending = pending_results.size();

    function automatic logic [15:0] crc16_byte(logic [15:0] c, logic [7:0] b);
        c = c ^ {8'h00, b};
        for (int k = 0; k < 8; k++)
            c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
        return c;
    endfunction

    function automatic t_result mk(logic [1:0] kind, logic [7:0] tx, logic ok,
                                   logic [7:0] val);
        t_result r;
        r.kind = kind;
        r.tx_data = tx;
        r.last = 1'b0;
        r.success = ok;
        r.reply_value = val;
        return r;
    endfunction

    task automatic queue_frame(ref t_result res[$]);
        logic [7:0]  fr[11];
        logic [3:0]  n;
        logic [15:0] c;
        c = 16'hFFFF;
        fr[0] = cfg_slave;
        if (mdl_write) begin
            fr[1] = 8'h10; fr[2] = mdl_reg_addr[15:8]; fr[3] = mdl_reg_addr[7:0];
            fr[4] = 8'h00; fr[5] = 8'h01; fr[6] = 8'h02;
            fr[7] = mdl_reg_val[15:8]; fr[8] = mdl_reg_val[7:0];
            n = 4'd11;
        end else begin
            fr[1] = 8'h01; fr[2] = 8'h00; fr[3] = 8'h06; fr[4] = 8'h00; fr[5] = 8'h07;
            n = 4'd8;
        end
        for (logic [3:0] i = 4'd0; i < n - 4'd2; i++) c = crc16_byte(c, fr[i]);
        fr[n - 4'd2] = c[7:0];
        fr[n - 4'd1] = c[15:8];
        for (logic [3:0] i = 4'd0; i < n; i++)
            res.push_back(mk(mrtu_pkg::KIND_TX, fr[i], 1'b0, 8'h00));
        mdl_phase = mrtu_pkg::PH_TURN;
        mdl_timer = mdl_write ? cfg_wr_turn : cfg_rd_turn;
    endtask

    task automatic attempt_failed(ref t_result res[$]);
        mdl_attempts = mdl_attempts + 4'd1;
        if (mdl_attempts >= cfg_retry || mdl_attempts == 4'd0) begin
            res.push_back(mk(mrtu_pkg::KIND_DONE, 8'h00, 1'b0, 8'h00));
            mdl_phase = mrtu_pkg::PH_IDLE;
        end else begin
            mdl_phase = mrtu_pkg::PH_GAP;
            mdl_timer = cfg_gap;
        end
    endtask

    task automatic predict_item(logic [1:0] cmd, logic [15:0] ra, logic [15:0] rv,
                                logic [7:0] rx);
        t_result    res[$];
        int         need;
        logic [2:0] lo_pos;
        logic [2:0] hi_pos;
        if (cmd == mrtu_pkg::CMD_READ || cmd == mrtu_pkg::CMD_WRITE) begin
            if (mdl_phase == mrtu_pkg::PH_IDLE) begin
                mdl_write = (cmd == mrtu_pkg::CMD_WRITE);
                if (mdl_write) begin
                    mdl_reg_addr = ra;
                    mdl_reg_val = rv;
                end
                mdl_attempts = 4'd0;
                queue_frame(res);
            end
        end else if (cmd == mrtu_pkg::CMD_RX) begin
            if (mdl_phase == mrtu_pkg::PH_LISTEN) begin
                need = mdl_write ? 8 : 6;
                lo_pos = mdl_write ? 3'd6 : 3'd4;
                hi_pos = mdl_write ? 3'd7 : 3'd5;
                if (mdl_count < need) begin
                    mdl_reply[mdl_count[2:0]] = rx;
                    if (mdl_count + 2 < need) mdl_crc = crc16_byte(mdl_crc, rx);
                    mdl_count = mdl_count + 4'd1;
                end
                if (mdl_count >= need) begin
                    if (mdl_reply[lo_pos] == mdl_crc[7:0] &&
                        mdl_reply[hi_pos] == mdl_crc[15:8]) begin
                        res.push_back(mk(mrtu_pkg::KIND_DONE, 8'h00, 1'b1,
                                         mdl_write ? 8'h00 : mdl_reply[3]));
                        mdl_phase = mrtu_pkg::PH_IDLE;
                    end else begin
                        attempt_failed(res);
                    end
                end
            end
        end else begin
            case (mdl_phase)
                mrtu_pkg::PH_TURN: begin
                    if (mdl_timer <= 1) begin
                        res.push_back(mk(mrtu_pkg::KIND_RELEASE, 8'h00, 1'b0, 8'h00));
                        mdl_phase = mrtu_pkg::PH_LISTEN;
                        mdl_count = 4'd0;
                        mdl_crc = 16'hFFFF;
                        mdl_timer = cfg_timeout;
                    end else begin
                        mdl_timer--;
                    end
                end
                mrtu_pkg::PH_LISTEN: begin
                    if (mdl_timer <= 1) attempt_failed(res);
                    else mdl_timer--;
                end
                mrtu_pkg::PH_GAP: begin
                    if (mdl_timer <= 1) queue_frame(res);
                    else mdl_timer--;
                end
                default: ;
            endcase
        end
        if (res.size() > 0) res[res.size()-1].last = 1'b1;
        foreach (res[i]) pending_results.push_back(res[i]);
    endtask

    always @(posedge i_clk) begin
        t_result got;
        t_result exp_r;
        if (!i_rst_n) begin
            cfg_slave <= 8'd1; cfg_retry <= 4'd10; cfg_timeout <= 10'd100;
            cfg_rd_turn <= 10'd5; cfg_wr_turn <= 10'd13; cfg_gap <= 10'd100;
            mdl_phase = mrtu_pkg::PH_IDLE; mdl_write = 1'b0;
            mdl_reg_addr = '0; mdl_reg_val = '0; mdl_count = '0;
            mdl_crc = 16'hFFFF; mdl_timer = '0; mdl_attempts = '0;
            pending_results.delete();
            o_errors <= 0;
            o_results <= 0;
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    mrtu_pkg::REG_SLAVE:   cfg_slave <= i_cfg.data[7:0];
                    mrtu_pkg::REG_RETRY:   cfg_retry <= i_cfg.data[3:0];
                    mrtu_pkg::REG_TIMEOUT: cfg_timeout <= i_cfg.data;
                    mrtu_pkg::REG_RD_TURN: cfg_rd_turn <= i_cfg.data;
                    mrtu_pkg::REG_WR_TURN: cfg_wr_turn <= i_cfg.data;
                    mrtu_pkg::REG_GAP:     cfg_gap <= i_cfg.data;
                    default: ;
                endcase
            end
            if (i_out.valid && i_out.ready) begin
                got = {i_out.kind, i_out.tx_data, i_out.last, i_out.success,
                       i_out.reply_value};
                o_results <= o_results + 1;
                if (pending_results.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %h",
                             $realtime, got);
                    o_errors <= o_errors + 1;
                end else begin
                    exp_r = pending_results.pop_front();
                    if (got !== exp_r) begin
                        $display("%0t: mismatch expected kind=%0d tx=%h last=%b ok=%b val=%h",
                                 $realtime, exp_r.kind, exp_r.tx_data, exp_r.last,
                                 exp_r.success, exp_r.reply_value);
                        $display("%0t:          actual   kind=%0d tx=%h last=%b ok=%b val=%h",
                                 $realtime, got.kind, got.tx_data, got.last,
                                 got.success, got.reply_value);
                        o_errors <= o_errors + 1;
                    end
                end
            end
            if (i_in.valid && i_in.ready)
                predict_item(i_in.command, i_in.register_address, i_in.register_value,
                             i_in.rx_byte);
        end
    end
endmodule

// ===== verif/tb_modbus_rtu_master_transaction_top.sv =====
module tb_modbus_rtu_master_transaction_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 1500000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    int   errors, pending, results;
    int   cycles = 0;
    int   sent = 0;
    bit   no_idle = 1'b0;
    bit   hold_rx = 1'b0;
    logic [15:0] frame_crc;

    logic [3:0]  cur_retry = 4'd10;
    logic [9:0]  cur_timeout = 10'd100;
    logic [9:0]  cur_rd_turn = 10'd5;
    logic [9:0]  cur_wr_turn = 10'd13;
    logic [9:0]  cur_gap = 10'd100;

    mrtu_in_if  in_ch();
    mrtu_out_if out_ch();
    mrtu_cfg_if cfg_ch();

    modbus_rtu_master_transaction_top u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_ch.sink), .o_out(out_ch.source),
        .i_cfg(cfg_ch.sink)
    );

    mrtu_checker u_chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_ch), .i_out(out_ch), .i_cfg(cfg_ch),
        .o_errors(errors), .o_pending(pending), .o_results(results)
    );

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // receiver: random stalls, long hold-off on request
    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_rx) out_ch.ready <= 1'b0;
            else out_ch.ready <= no_idle || ($urandom_range(99) >= 22);
        end
    end

    initial begin
        in_ch.valid = 1'b0;
        in_ch.command = mrtu_pkg::CMD_TICK;
        in_ch.register_address = '0;
        in_ch.register_value = '0;
        in_ch.rx_byte = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = mrtu_pkg::REG_SLAVE;
        cfg_ch.data = '0;
    end

    function automatic logic [15:0] crc_step(logic [15:0] c, logic [7:0] b);
        c = c ^ {8'h00, b};
        for (int k = 0; k < 8; k++) c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
        return c;
    endfunction

    // a wait of zero ticks still ends on the first tick
    function automatic int tick_count(logic [9:0] v);
        return (v == 10'd0) ? 1 : int'(v);
    endfunction

    // valid stays high after a transfer; the next send or drain moves it
    task automatic send(logic [1:0] cmd, logic [15:0] ra = 16'h0000,
                        logic [15:0] rv = 16'h0000, logic [7:0] rx = 8'h00);
        if (!no_idle && $urandom_range(99) < 22) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
            while (!no_idle && $urandom_range(99) < 22) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.command <= cmd;
        in_ch.register_address <= ra;
        in_ch.register_value <= rv;
        in_ch.rx_byte <= rx;
        do @(posedge i_clk); while (!in_ch.ready);
        sent++;
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [9:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= val;
        do @(posedge i_clk); while (!cfg_ch.ready);
    endtask

    task automatic configure(logic [7:0] sa, logic [3:0] rl, logic [9:0] tmo,
                             logic [9:0] rt, logic [9:0] wt, logic [9:0] gp);
        write_reg(mrtu_pkg::REG_SLAVE, {2'b00, sa});
        write_reg(mrtu_pkg::REG_RETRY, {6'd0, rl});
        write_reg(mrtu_pkg::REG_TIMEOUT, tmo);
        write_reg(mrtu_pkg::REG_RD_TURN, rt);
        write_reg(mrtu_pkg::REG_WR_TURN, wt);
        write_reg(mrtu_pkg::REG_GAP, gp);
        cfg_ch.valid <= 1'b0;
        @(posedge i_clk);
        cur_retry = rl;
        cur_timeout = tmo;
        cur_rd_turn = rt;
        cur_wr_turn = wt;
        cur_gap = gp;
    endtask

    task automatic ticks(int n);
        repeat (n) send(mrtu_pkg::CMD_TICK);
    endtask

    // reply to a request; corrupt flips CRC so the attempt fails
    task automatic reply(logic wr, logic [7:0] sa, logic [7:0] val, bit corrupt);
        logic [7:0] b[8];
        logic [3:0] n;
        n = wr ? 4'd8 : 4'd6;
        b[0] = sa; b[1] = wr ? 8'h10 : 8'h01;
        for (logic [3:0] i = 4'd2; i < n - 4'd2; i++) b[i[2:0]] = 8'($urandom);
        if (!wr) b[3] = val;
        frame_crc = 16'hFFFF;
        for (logic [3:0] i = 4'd0; i < n - 4'd2; i++)
            frame_crc = crc_step(frame_crc, b[i[2:0]]);
        b[3'(n - 4'd2)] = frame_crc[7:0] ^ (corrupt ? 8'(8'h01 << $urandom_range(7)) : 8'h00);
        b[3'(n - 4'd1)] = frame_crc[15:8];
        for (logic [3:0] i = 4'd0; i < n; i++)
            send(mrtu_pkg::CMD_RX, 16'h0000, 16'h0000, b[i[2:0]]);
    endtask

    // one whole transaction that ends in a done result; failed attempts are
    // bad replies or, with a short timeout, silence until the timeout
    task automatic transaction(logic [7:0] sa, int fails);
        logic wr;
        int   limit;
        int   turn;
        wr = 1'($urandom_range(1));
        limit = (cur_retry == 4'd0) ? 1 : int'(cur_retry);
        turn = tick_count(wr ? cur_wr_turn : cur_rd_turn);
        send(wr ? mrtu_pkg::CMD_WRITE : mrtu_pkg::CMD_READ, 16'($urandom), 16'($urandom));
        if ($urandom_range(3) == 0) send(mrtu_pkg::CMD_READ);
        if ($urandom_range(3) == 0) send(mrtu_pkg::CMD_RX, 16'h0000, 16'h0000, 8'($urandom));
        ticks(turn);
        for (int a = 0; a <= fails; a++) begin
            if (a < fails) begin
                if (cur_timeout <= 10'd8 && $urandom_range(1) == 0)
                    ticks(tick_count(cur_timeout));
                else
                    reply(wr, sa, 8'($urandom), 1'b1);
                if (a + 1 >= limit) break;
                ticks(tick_count(cur_gap));
                ticks(turn);
            end else begin
                reply(wr, sa, 8'($urandom), 1'b0);
            end
        end
    endtask

    initial begin
        logic [7:0] sa;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: default config, idle noise, extremes, timeout, retries
        send(mrtu_pkg::CMD_TICK);
        send(mrtu_pkg::CMD_RX, 16'h0000, 16'h0000, 8'hFF);
        send(mrtu_pkg::CMD_READ);
        send(mrtu_pkg::CMD_WRITE, 16'hFFFF, 16'hFFFF);
        ticks(5);
        reply(1'b0, 8'd1, 8'hA5, 1'b0);
        drain();
        configure(8'hFF, 4'd1, 10'd1, 10'd0, 10'd0, 10'd0);
        send(mrtu_pkg::CMD_WRITE, 16'hFFFF, 16'hFFFF);
        ticks(2);
        send(mrtu_pkg::CMD_WRITE, 16'h0000, 16'h0000);
        send(mrtu_pkg::CMD_READ);
        reply(1'b0, 8'hFF, 8'h00, 1'b0);
        ticks(2);
        drain();
        configure(8'h00, 4'd0, 10'd1023, 10'd1, 10'd1, 10'd1);
        send(mrtu_pkg::CMD_READ);
        ticks(1);
        reply(1'b0, 8'h00, 8'h00, 1'b1);
        drain();
        configure(8'h5A, 4'd15, 10'd3, 10'd2, 10'd3, 10'd2);
        send(mrtu_pkg::CMD_WRITE, 16'h1234, 16'h8001);
        ticks(3);
        reply(1'b1, 8'h5A, 8'h00, 1'b1);
        ticks(2);
        ticks(4);
        reply(1'b1, 8'h5A, 8'h00, 1'b0);
        drain();

        // receiver holds off while sender keeps going
        configure(8'h11, 4'd3, 10'd1023, 10'd1, 10'd1, 10'd2);
        hold_rx = 1'b1;
        fork
            begin
                repeat (600) @(posedge i_clk);
                hold_rx = 1'b0;
            end
            transaction(8'h11, 1);
        join
        drain();

        // no-idle stretch
        no_idle = 1'b1;
        configure(8'h22, 4'd4, 10'd1023, 10'd1, 10'd1, 10'd1);
        repeat (4) transaction(8'h22, $urandom_range(2));
        drain();
        no_idle = 1'b0;

        // random phases
        while (sent < 240) begin
            sa = 8'($urandom);
            configure(sa, 4'($urandom_range(15)), 10'($urandom_range(1, 8)),
                      10'($urandom_range(4)), 10'($urandom_range(4)),
                      10'($urandom_range(4)));
            repeat (2) begin
                transaction(sa, $urandom_range(3));
                ticks(2);
            end
            drain();
        end

        drain();
        $display("Sent %0d items, checked %0d results: reads, writes, retries, timeouts,",
                 sent, results);
        $display("idle noise, register extremes, output hold-off and no-idle stretch.");
        if (errors == 0 && pending == 0) $display("TB_OK");
        else $display("TB_ERROR");
        $finish;
    end
endmodule

// ===== modbus_rtu_master_transaction_top.f =====
hw/rtl/mrtu_pkg.sv
hw/rtl/mrtu_if.sv
hw/rtl/mrtu_crc.sv
hw/rtl/modbus_rtu_master_transaction_top.sv
hw/rtl/mrtu_chk.sv
verif/mrtu_checker.sv
verif/tb_modbus_rtu_master_transaction_top.sv
